/* hw/rtl/tce_pkg.sv */
// Shared types, opcodes and constants of the toy CPU execute unit.
package tce_pkg;

    localparam int DATA_W        = 16;
    localparam int REG_IDX_W     = 8;
    localparam int OPCODE_W      = 4;
    localparam int REG_COUNT_DEF = 256;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] FLAG_REG = 8'hF1;
    localparam logic [DATA_W-1:0]    PROG_LEN_RESET = 16'hFFFF;

    // Configuration register indexes (word address)
    localparam logic [0:0] CFG_PROGRAM_LENGTH = 1'b0;

    // Instruction opcodes
    localparam logic [OPCODE_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_JMP     = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_JE      = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_MOV_REG = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_MOV_IMM = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_ADD_REG = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_ADD_IMM = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_CMP_REG = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_CMP_IMM = 4'd8;

    typedef enum logic [2:0] {
        K_NOP,
        K_JMP,
        K_JE,
        K_MOV,
        K_ADD,
        K_CMP
    } t_kind;

    // Decoded instruction handed from front to back
    typedef struct packed {
        t_kind                kind;
        logic                 use_imm;
        logic [2:0]           pc_step;
        logic [REG_IDX_W-1:0] dest;
        logic [REG_IDX_W-1:0] src;
        logic [DATA_W-1:0]    imm;
    } t_uop;

    // One retired instruction
    typedef struct packed {
        logic [DATA_W-1:0]    next_pc;
        logic                 write_enable;
        logic [REG_IDX_W-1:0] write_index;
        logic [DATA_W-1:0]    write_value;
        logic                 add_overflow;
        logic                 jump_out_of_range;
        logic [DATA_W-1:0]    equal_flag;
    } t_result;

endpackage

/* hw/rtl/tce_regfile.sv */
// Register file memory with per-entry valid bits and registered read ports.
module tce_regfile import tce_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [REG_IDX_W-1:0] i_waddr,
    input  logic [DATA_W-1:0]    i_wdata,
    input  logic                 i_re,
    input  logic [REG_IDX_W-1:0] i_raddr_a,
    input  logic [REG_IDX_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0]    o_rdata_a,
    output logic [DATA_W-1:0]    o_rdata_b
);

    localparam int IDX_W = $clog2(REG_COUNT);
    localparam logic [REG_IDX_W:0] COUNT_LIM = (REG_IDX_W+1)'(REG_COUNT);

    logic [DATA_W-1:0]    r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [DATA_W-1:0]    r_rd_a;
    logic [DATA_W-1:0]    r_rd_b;
    logic                 r_rd_vld_a;
    logic                 r_rd_vld_b;
    logic                 w_inr_w;
    logic                 w_inr_a;
    logic                 w_inr_b;

    // Indexes at or above the register count read zero and drop writes
    assign w_inr_w = {1'b0, i_waddr}   < COUNT_LIM;
    assign w_inr_a = {1'b0, i_raddr_a} < COUNT_LIM;
    assign w_inr_b = {1'b0, i_raddr_b} < COUNT_LIM;

    // Write and read the storage array
    always_ff @(posedge i_clk) begin
        if (i_we && w_inr_w) begin
            r_mem[i_waddr[IDX_W-1:0]] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a[IDX_W-1:0]];
            r_rd_b <= r_mem[i_raddr_b[IDX_W-1:0]];
        end
    end

    // Track written entries; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_vld_a <= 1'b0;
            r_rd_vld_b <= 1'b0;
        end else begin
            if (i_we && w_inr_w) begin
                r_vld[i_waddr[IDX_W-1:0]] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld_a <= w_inr_a && r_vld[i_raddr_a[IDX_W-1:0]];
                r_rd_vld_b <= w_inr_b && r_vld[i_raddr_b[IDX_W-1:0]];
            end
        end
    end

    assign o_rdata_a = r_rd_vld_a ? r_rd_a : '0;
    assign o_rdata_b = r_rd_vld_b ? r_rd_b : '0;

endmodule

/* hw/rtl/tce_front.sv */
// Front end: decode incoming instructions and queue them for the back end.
module tce_front import tce_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [REG_IDX_W-1:0] i_dest_reg,
    input  logic [REG_IDX_W-1:0] i_src_reg,
    input  logic [DATA_W-1:0]    i_immediate,
    output logic                 o_full,
    output logic                 o_valid,
    output t_uop                 o_uop,
    input  logic                 i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_uop             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    t_uop             w_dec;
    logic             w_push;
    logic             w_pop;

    // Classify the opcode
    always_comb begin
        w_dec.dest = i_dest_reg;
        w_dec.src  = i_src_reg;
        w_dec.imm  = i_immediate;
        unique case (i_opcode)
            OP_JMP: begin
                w_dec.kind = K_JMP; w_dec.use_imm = 1'b1; w_dec.pc_step = 3'd0;
            end
            OP_JE: begin
                w_dec.kind = K_JE; w_dec.use_imm = 1'b1; w_dec.pc_step = 3'd3;
            end
            OP_MOV_REG: begin
                w_dec.kind = K_MOV; w_dec.use_imm = 1'b0; w_dec.pc_step = 3'd3;
            end
            OP_MOV_IMM: begin
                w_dec.kind = K_MOV; w_dec.use_imm = 1'b1; w_dec.pc_step = 3'd4;
            end
            OP_ADD_REG: begin
                w_dec.kind = K_ADD; w_dec.use_imm = 1'b0; w_dec.pc_step = 3'd3;
            end
            OP_ADD_IMM: begin
                w_dec.kind = K_ADD; w_dec.use_imm = 1'b1; w_dec.pc_step = 3'd4;
            end
            OP_CMP_REG: begin
                w_dec.kind = K_CMP; w_dec.use_imm = 1'b0; w_dec.pc_step = 3'd3;
            end
            OP_CMP_IMM: begin
                w_dec.kind = K_CMP; w_dec.use_imm = 1'b1; w_dec.pc_step = 3'd4;
            end
            default: begin
                // nop and unused opcodes
                w_dec.kind = K_NOP; w_dec.use_imm = 1'b0; w_dec.pc_step = 3'd1;
            end
        endcase
    end

    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_uop   = r_q[r_rptr];

    // Store decoded transactions
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_dec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/tce_back.sv */
// Back end: operand read, execute, architectural update and result register.
module tce_back import tce_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_uop              i_q_uop,
    output logic              o_q_pop,
    input  logic [DATA_W-1:0] i_prog_len,
    output logic              o_empty,
    output t_result           o_result,
    input  logic              i_pop
);

    localparam logic [REG_IDX_W:0] COUNT_LIM = (REG_IDX_W+1)'(REG_COUNT);

    logic                 r_b_valid;
    t_uop                 r_b_uop;
    logic                 r_fwd_a;
    logic                 r_fwd_b;
    logic [DATA_W-1:0]    r_fwd_val;
    logic [DATA_W-1:0]    r_pc;
    logic [DATA_W-1:0]    r_flag;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 w_issue;
    logic                 w_done;
    logic [DATA_W-1:0]    w_rd_a;
    logic [DATA_W-1:0]    w_rd_b;
    logic [DATA_W-1:0]    w_op_a;
    logic [DATA_W-1:0]    w_op_b;
    logic [DATA_W:0]      w_sum;
    logic                 w_d_inr;
    logic                 n_we;
    logic [REG_IDX_W-1:0] n_idx;
    logic [DATA_W-1:0]    n_val;
    logic [DATA_W-1:0]    n_pc;
    logic                 n_ovf;
    logic                 n_oor;
    logic [DATA_W-1:0]    n_flag;

    assign w_done  = r_b_valid && (!r_out_valid || i_pop);
    assign w_issue = i_q_valid && (!r_b_valid || w_done);
    assign o_q_pop = w_issue;

    tce_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_done && n_we),
        .i_waddr   (n_idx),
        .i_wdata   (n_val),
        .i_re      (w_issue),
        .i_raddr_a (i_q_uop.dest),
        .i_raddr_b (i_q_uop.src),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // Select operands, bypassing the write retired at the read edge
    assign w_op_a  = r_fwd_a ? r_fwd_val : w_rd_a;
    assign w_op_b  = r_b_uop.use_imm ? r_b_uop.imm : (r_fwd_b ? r_fwd_val : w_rd_b);
    assign w_sum   = {1'b0, w_op_a} + {1'b0, w_op_b};
    assign w_d_inr = {1'b0, r_b_uop.dest} < COUNT_LIM;

    // Execute the instruction in stage B
    always_comb begin
        n_pc  = r_pc + DATA_W'(r_b_uop.pc_step);
        n_we  = 1'b0;
        n_idx = r_b_uop.dest;
        n_val = '0;
        n_ovf = 1'b0;
        n_oor = 1'b0;
        unique case (r_b_uop.kind)
            K_JMP: begin
                n_pc  = r_b_uop.imm;
                n_oor = r_b_uop.imm > i_prog_len;
            end
            K_JE: begin
                if (r_flag != '0) n_pc = r_b_uop.imm;
            end
            K_MOV: begin
                n_we  = w_d_inr;
                n_val = w_op_b;
            end
            K_ADD: begin
                if (w_sum[DATA_W]) begin
                    n_ovf = 1'b1;
                end else begin
                    n_we  = w_d_inr;
                    n_val = w_sum[DATA_W-1:0];
                end
            end
            K_CMP: begin
                n_we  = 1'b1;
                n_idx = FLAG_REG;
                n_val = DATA_W'(w_op_a == w_op_b);
            end
            default: begin
            end
        endcase
        if (!n_we) begin
            n_idx = '0;
            n_val = '0;
        end
        n_flag = (n_we && (n_idx == FLAG_REG)) ? n_val : r_flag;
    end

    // Hold stage B payload and bypass data
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_b_uop   <= i_q_uop;
            r_fwd_val <= n_val;
        end
    end

    // Advance stage B, architectural state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_a     <= 1'b0;
            r_fwd_b     <= 1'b0;
            r_pc        <= '0;
            r_flag      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_b_valid <= 1'b1;
                r_fwd_a   <= w_done && n_we && (n_idx == i_q_uop.dest);
                r_fwd_b   <= w_done && n_we && (n_idx == i_q_uop.src);
            end else if (w_done) begin
                r_b_valid <= 1'b0;
            end
            if (w_done) begin
                r_pc        <= n_pc;
                r_flag      <= n_flag;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the retired transaction
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out.next_pc           <= n_pc;
            r_out.write_enable      <= n_we;
            r_out.write_index       <= n_idx;
            r_out.write_value       <= n_val;
            r_out.add_overflow      <= n_ovf;
            r_out.jump_out_of_range <= n_oor;
            r_out.equal_flag        <= n_flag;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

/* hw/rtl/toy_cpu_execute_unit.sv */
// Top level of the toy CPU execute unit: front end, back end and config port.
//
// Usage: decoded instructions enter through a queue-style port (i_push, o_full);
// a transaction is taken at a clock edge with i_push high and o_full low.
// Results leave through a queue-style port (o_empty, i_pop): the oldest result
// sits on the o_ ports while o_empty is low and is taken when i_pop is high.
// The front end decodes each instruction into a four-entry queue; the back end
// reads operands from the register file memory (registered reads), executes,
// updates PC, flag and register file, and loads a result register.
// An accepted instruction passes through the queue, stage B and the result register.
// Throughput: one instruction per cycle while the receiver keeps popping, set by
// the single execute stage, with a bypass around the regfile read-modify-write.
// Reset clears the PC, the flag copy, the queue and the register file valid
// bits at once (no clearing pass); program_length returns to 0xFFFF.
// When the receiver stalls, the result register holds, the execute stage
// holds behind it, and the input queue fills before o_full rises.
// program_length is written over the APB port at byte address 0; it should
// only be changed while no instruction is in flight.
module toy_cpu_execute_unit import tce_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [REG_IDX_W-1:0]  i_dest_reg,
    input  logic [REG_IDX_W-1:0]  i_src_reg,
    input  logic [DATA_W-1:0]     i_immediate,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [DATA_W-1:0]     o_next_pc,
    output logic                  o_write_enable,
    output logic [REG_IDX_W-1:0]  o_write_index,
    output logic [DATA_W-1:0]     o_write_value,
    output logic                  o_add_overflow,
    output logic                  o_jump_out_of_range,
    output logic [DATA_W-1:0]     o_equal_flag,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic              r_prog_len;
    logic [DATA_W-1:0] r_prog_len_q;
    logic              w_cfg_wr;
    logic              w_q_valid;
    logic              w_q_pop;
    t_uop              w_q_uop;
    t_result           w_result;

    // Configuration register write and readback
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_PROGRAM_LENGTH);
    assign prdata   = (paddr[2] == CFG_PROGRAM_LENGTH) ?
                      CFG_DATA_W'(r_prog_len_q) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len_q <= PROG_LEN_RESET;
            r_prog_len   <= 1'b0;
        end else begin
            r_prog_len <= w_cfg_wr;
            if (w_cfg_wr) begin
                r_prog_len_q <= pwdata[DATA_W-1:0];
            end
        end
    end

    tce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_opcode    (i_opcode),
        .i_dest_reg  (i_dest_reg),
        .i_src_reg   (i_src_reg),
        .i_immediate (i_immediate),
        .o_full      (o_full),
        .o_valid     (w_q_valid),
        .o_uop       (w_q_uop),
        .i_pop       (w_q_pop)
    );

    tce_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_uop    (w_q_uop),
        .o_q_pop    (w_q_pop),
        .i_prog_len (r_prog_len_q),
        .o_empty    (o_empty),
        .o_result   (w_result),
        .i_pop      (i_pop)
    );

    assign o_next_pc           = w_result.next_pc;
    assign o_write_enable      = w_result.write_enable;
    assign o_write_index       = w_result.write_index;
    assign o_write_value       = w_result.write_value;
    assign o_add_overflow      = w_result.add_overflow;
    assign o_jump_out_of_range = w_result.jump_out_of_range;
    assign o_equal_flag        = w_result.equal_flag;

    // The back end only drains a queue that holds a transaction
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    // No result is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result offered after reset");

    // A suppressed write reports index and value zero
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_write_enable) |-> (o_write_index == '0 && o_write_value == '0))
        else $error("write fields set without write enable");

    // An add overflow never writes the register file
    a_ovf_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_add_overflow) |-> !o_write_enable)
        else $error("overflowing add reported a write");

    // A config write lands in program_length
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_prog_len && r_prog_len_q == $past(pwdata[DATA_W-1:0])))
        else $error("program_length not updated");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the toy CPU execute unit: queue-fed driver, monitor, predictor.
module tb_top;
    import tce_pkg::*;

    localparam int TB_REG_COUNT = REG_COUNT_DEF;
    localparam logic [CFG_ADDR_W-1:0] PLEN_ADDR = CFG_ADDR_W'(4 * CFG_PROGRAM_LENGTH);
    localparam int RAND_PER_PHASE = 225;

    typedef struct {
        logic [OPCODE_W-1:0]  opcode;
        logic [REG_IDX_W-1:0] dest;
        logic [REG_IDX_W-1:0] src;
        logic [DATA_W-1:0]    imm;
    } t_insn;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_push = 1'b0;
    logic                  o_full;
    logic [OPCODE_W-1:0]   i_opcode = '0;
    logic [REG_IDX_W-1:0]  i_dest_reg = '0;
    logic [REG_IDX_W-1:0]  i_src_reg = '0;
    logic [DATA_W-1:0]     i_immediate = '0;
    logic                  o_empty;
    logic                  i_pop = 1'b0;
    logic [DATA_W-1:0]     o_next_pc;
    logic                  o_write_enable;
    logic [REG_IDX_W-1:0]  o_write_index;
    logic [DATA_W-1:0]     o_write_value;
    logic                  o_add_overflow;
    logic                  o_jump_out_of_range;
    logic [DATA_W-1:0]     o_equal_flag;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Instructions waiting to be driven, and retirements still owed by the block
    t_insn   pending_insns[$];
    t_result owed_retires[$];

    // Architectural copy kept by the predictor
    logic [DATA_W-1:0] arch_regs [TB_REG_COUNT];
    logic [DATA_W-1:0] arch_pc;
    logic [DATA_W-1:0] plen_copy;

    logic        insn_taken = 1'b0;
    int unsigned n_accepted = 0;
    int unsigned n_errors = 0;
    int unsigned hold_left = 0;
    logic        hold_used = 1'b0;
    logic        calm;

    toy_cpu_execute_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (i_push),
        .o_full              (o_full),
        .i_opcode            (i_opcode),
        .i_dest_reg          (i_dest_reg),
        .i_src_reg           (i_src_reg),
        .i_immediate         (i_immediate),
        .o_empty             (o_empty),
        .i_pop               (i_pop),
        .o_next_pc           (o_next_pc),
        .o_write_enable      (o_write_enable),
        .o_write_index       (o_write_index),
        .o_write_value       (o_write_value),
        .o_add_overflow      (o_add_overflow),
        .o_jump_out_of_range (o_jump_out_of_range),
        .o_equal_flag        (o_equal_flag),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // Clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("toy_cpu_execute_unit: mismatch");
        $finish;
    end

    // No idling on either side over this window of transactions
    assign calm = (n_accepted >= 700) && (n_accepted < 900);

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %s: got %0h want %0h (transaction %0d)", what, got, want,
                 n_accepted);
        n_errors++;
    endtask

    function automatic logic [DATA_W-1:0] read_arch(input logic [REG_IDX_W-1:0] idx);
        if (int'(idx) >= TB_REG_COUNT) return '0;
        return arch_regs[idx];
    endfunction

    function automatic logic write_arch(input logic [REG_IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] val);
        if (int'(idx) >= TB_REG_COUNT) return 1'b0;
        arch_regs[idx] = val;
        return 1'b1;
    endfunction

    // Execute one instruction on the architectural copy and build its retirement
    function automatic t_result exec_insn(input t_insn it);
        t_result           r;
        logic              use_imm;
        logic [DATA_W-1:0] operand;
        logic [DATA_W-1:0] step_pc;
        logic [DATA_W-1:0] nxt;
        logic [DATA_W:0]   sum;
        logic              wrote;
        r = '0;
        wrote = 1'b0;
        use_imm = (it.opcode == OP_MOV_IMM) || (it.opcode == OP_ADD_IMM) ||
                  (it.opcode == OP_CMP_IMM);
        operand = use_imm ? it.imm : read_arch(it.src);
        step_pc = arch_pc + (use_imm ? 16'd4 : 16'd3);
        nxt = arch_pc + 16'd1;
        case (it.opcode)
            OP_JMP: begin
                r.jump_out_of_range = (it.imm > plen_copy);
                nxt = it.imm;
            end
            OP_JE: begin
                nxt = (read_arch(FLAG_REG) != '0) ? it.imm : arch_pc + 16'd3;
            end
            OP_MOV_REG, OP_MOV_IMM: begin
                wrote = write_arch(it.dest, operand);
                r.write_index = it.dest;
                r.write_value = operand;
                nxt = step_pc;
            end
            OP_ADD_REG, OP_ADD_IMM: begin
                sum = {1'b0, read_arch(it.dest)} + {1'b0, operand};
                if (sum[DATA_W]) begin
                    r.add_overflow = 1'b1;
                end else begin
                    wrote = write_arch(it.dest, sum[DATA_W-1:0]);
                    r.write_index = it.dest;
                    r.write_value = sum[DATA_W-1:0];
                end
                nxt = step_pc;
            end
            OP_CMP_REG, OP_CMP_IMM: begin
                r.write_value = (read_arch(it.dest) == operand) ? 16'd1 : 16'd0;
                wrote = write_arch(FLAG_REG, r.write_value);
                r.write_index = FLAG_REG;
                nxt = step_pc;
            end
            default: begin
            end
        endcase
        if (!wrote) begin
            r.write_index = '0;
            r.write_value = '0;
        end
        r.write_enable = wrote;
        arch_pc = nxt;
        r.next_pc = nxt;
        r.equal_flag = read_arch(FLAG_REG);
        return r;
    endfunction

    // Capture accepted instructions and predict their retirement
    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full) begin
            owed_retires.push_back(exec_insn('{i_opcode, i_dest_reg, i_src_reg, i_immediate}));
            n_accepted <= n_accepted + 1;
            insn_taken <= 1'b1;
        end else begin
            insn_taken <= 1'b0;
        end
    end

    // Drive instructions from the pending queue, idling at random
    always @(negedge i_clk) begin
        t_insn it;
        if (!i_push || insn_taken) begin
            if (i_rst_n && pending_insns.size() != 0 &&
                (calm || $urandom_range(99) >= 33)) begin
                it = pending_insns.pop_front();
                i_opcode    <= it.opcode;
                i_dest_reg  <= it.dest;
                i_src_reg   <= it.src;
                i_immediate <= it.imm;
                i_push      <= 1'b1;
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Hold off the receiver once for a long stretch so the input stalls
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && n_accepted >= 300) begin
            hold_left <= 80;
            hold_used <= 1'b1;
        end
    end

    // Pop results, idling at random
    always @(negedge i_clk) begin
        i_pop <= (hold_left == 0) && (calm || $urandom_range(99) >= 33);
    end

    // Compare each retired transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (owed_retires.size() == 0) begin
                report_mismatch("unexpected retirement, next_pc", 32'(o_next_pc), 0);
            end else begin
                want = owed_retires.pop_front();
                if (o_next_pc !== want.next_pc)
                    report_mismatch("next_pc", 32'(o_next_pc), 32'(want.next_pc));
                if (o_write_enable !== want.write_enable)
                    report_mismatch("write_enable", 32'(o_write_enable),
                                    32'(want.write_enable));
                if (o_write_index !== want.write_index)
                    report_mismatch("write_index", 32'(o_write_index),
                                    32'(want.write_index));
                if (o_write_value !== want.write_value)
                    report_mismatch("write_value", 32'(o_write_value),
                                    32'(want.write_value));
                if (o_add_overflow !== want.add_overflow)
                    report_mismatch("add_overflow", 32'(o_add_overflow),
                                    32'(want.add_overflow));
                if (o_jump_out_of_range !== want.jump_out_of_range)
                    report_mismatch("jump_out_of_range", 32'(o_jump_out_of_range),
                                    32'(want.jump_out_of_range));
                if (o_equal_flag !== want.equal_flag)
                    report_mismatch("equal_flag", 32'(o_equal_flag),
                                    32'(want.equal_flag));
            end
        end
    end

    task automatic queue_insn(input logic [OPCODE_W-1:0] op, input logic [REG_IDX_W-1:0] d,
                              input logic [REG_IDX_W-1:0] s, input logic [DATA_W-1:0] imm);
        pending_insns.push_back('{op, d, s, imm});
    endtask

    // Favor a few registers so values get reused, compared and overflowed
    function automatic logic [REG_IDX_W-1:0] pick_reg();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return REG_IDX_W'($urandom_range(7));
        if (r < 70) return FLAG_REG;
        if (r < 75) return '1;
        return REG_IDX_W'($urandom_range(255));
    endfunction

    task automatic queue_random(input int unsigned count);
        logic [OPCODE_W-1:0] op;
        logic [DATA_W-1:0]   imm;
        int unsigned         r;
        repeat (count) begin
            op = ($urandom_range(99) < 4) ? OPCODE_W'($urandom_range(15, 9))
                                          : OPCODE_W'($urandom_range(8, 0));
            r = $urandom_range(99);
            if (r < 15)      imm = '0;
            else if (r < 25) imm = '1;
            else if (r < 35) imm = 16'd1;
            else if (r < 55) imm = DATA_W'($urandom_range(15));
            else             imm = DATA_W'($urandom_range(16'hFFFF));
            queue_insn(op, pick_reg(), pick_reg(), imm);
        end
    endtask

    // Wait until every instruction has been driven and retired
    task automatic drain();
        while (pending_insns.size() != 0 || i_push || owed_retires.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write program_length over the config port: setup, then access
    task automatic cfg_write(input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PLEN_ADDR;
        pwdata  <= {16'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        plen_copy = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Read program_length back and check it
    task automatic cfg_read_check();
        logic [CFG_DATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PLEN_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {16'h0, plen_copy})
            report_mismatch("program_length readback", got, {16'h0, plen_copy});
    endtask

    // Stimulus: directed instructions, then random phases under several lengths
    initial begin
        logic [DATA_W-1:0] plen_set [4];
        foreach (arch_regs[i]) arch_regs[i] = '0;
        arch_pc = '0;
        plen_copy = PROG_LEN_RESET;
        plen_set = '{DATA_W'($urandom_range(16'hFFFE, 1)), 16'h8000, 16'hFFFF, 16'h0001};

        while (!i_rst_n) @(negedge i_clk);
        cfg_read_check();

        // Overflow, carry edge, compare, taken je and PC wrap
        queue_insn(OP_NOP, 8'd0, 8'd0, 16'h0000);
        queue_insn(OP_MOV_IMM, 8'd0, 8'd0, 16'hFFFF);
        queue_insn(OP_MOV_IMM, 8'd1, 8'd0, 16'h0001);
        queue_insn(OP_ADD_REG, 8'd0, 8'd1, 16'h0000);
        queue_insn(OP_ADD_IMM, 8'd1, 8'd0, 16'hFFFE);
        queue_insn(OP_MOV_REG, 8'hFF, 8'd1, 16'h0000);
        queue_insn(OP_CMP_REG, 8'd0, 8'hFF, 16'h0000);
        queue_insn(OP_JE, 8'd0, 8'd0, 16'hFFFE);
        queue_insn(OP_NOP, 8'hFF, 8'hFF, 16'hFFFF);
        queue_insn(OP_MOV_IMM, 8'd2, 8'd0, 16'h0000);
        queue_insn(OP_CMP_IMM, 8'd1, 8'd0, 16'h1234);
        queue_insn(OP_JE, 8'd0, 8'd0, 16'h0040);
        queue_insn(OP_JMP, 8'd0, 8'd0, 16'hFFFF);
        queue_insn(OP_ADD_REG, 8'd2, 8'd2, 16'h0000);
        // Flag written directly, then used by je and as an add operand
        queue_insn(OP_MOV_IMM, FLAG_REG, 8'd0, 16'h8000);
        queue_insn(OP_JE, 8'd0, 8'd0, 16'h1000);
        queue_insn(OP_ADD_IMM, FLAG_REG, 8'd0, 16'h8000);
        queue_insn(OP_ADD_IMM, FLAG_REG, 8'd0, 16'h7FFF);
        // Unused opcodes act as nop
        queue_insn(4'd9, 8'd3, 8'd4, 16'h5555);
        queue_insn(4'd15, 8'hFF, 8'hFF, 16'hFFFF);
        queue_insn(OP_CMP_REG, 8'hFF, 8'd0, 16'h0000);
        queue_insn(OP_MOV_REG, 8'd3, 8'd200, 16'h0000);
        queue_random(RAND_PER_PHASE);
        drain();

        // Zero length: every nonzero jmp target is out of range, je never flagged
        cfg_write(16'h0000);
        cfg_read_check();
        queue_insn(OP_JMP, 8'd0, 8'd0, 16'h0000);
        queue_insn(OP_JMP, 8'd0, 8'd0, 16'h0001);
        queue_insn(OP_JE, 8'd0, 8'd0, 16'hFFFF);
        queue_insn(OP_JMP, 8'd0, 8'd0, 16'hFFFF);
        queue_random(RAND_PER_PHASE);
        drain();

        foreach (plen_set[i]) begin
            cfg_write(plen_set[i]);
            cfg_read_check();
            queue_random(RAND_PER_PHASE);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("toy_cpu_execute_unit: match");
        end else begin
            $display("toy_cpu_execute_unit: mismatch");
        end
        $finish;
    end

endmodule
